>>> rtl/qrs_pkg.sv
package qrs_pkg;

   // Fixed-point format of coefficients and roots.
   localparam int FRAC_BITS = 16;

   // Square root: a radicand below 2^66, padded to an even 68 bits, gives a 34-bit root.
   localparam int RAD_W  = 68;
   localparam int ROOT_W = 34;
   localparam int REM_W  = 36;

   // Division: the numerator magnitude stays below 2^35 before scaling.
   // The denominator (b or 2a) has a magnitude of at most 2^32.
   localparam int NUM_W  = 35 + FRAC_BITS;
   localparam int DEN_W  = 33;

   localparam int SQRT_CELLS = ROOT_W;
   localparam int DIV_CELLS  = NUM_W;

   // Cycles from an accepted item to its result strobe.
   localparam int LATENCY = 5 + SQRT_CELLS + DIV_CELLS;

   localparam logic [2:0] CODE_INF  = 3'd0;
   localparam logic [2:0] CODE_NONE = 3'd1;
   localparam logic [2:0] CODE_LIN  = 3'd2;
   localparam logic [2:0] CODE_DBL  = 3'd3;
   localparam logic [2:0] CODE_TWO  = 3'd4;

   typedef struct packed {
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] coef_c;
   } req_type;

   typedef struct packed {
      logic [2:0]         case_code;
      logic signed [31:0] root_one;
      logic signed [31:0] root_two;
      logic               saturated;
   } rsp_type;

   // Values carried beside the square root until the numerators are formed.
   typedef struct packed {
      logic [2:0]         code;
      logic signed [32:0] base1;
      logic signed [32:0] negb;
      logic               den_neg;
      logic [DEN_W-1:0]   den_mag;
   } sq_pay_type;

   typedef struct packed {
      logic              valid;
      sq_pay_type        pay;
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_stage_type;

   typedef struct packed {
      logic [2:0] code;
      logic [1:0] neg;
   } div_pay_type;

   typedef struct packed {
      logic                       valid;
      div_pay_type                pay;
      logic [DEN_W-1:0]           den;
      logic [1:0][DEN_W-1:0]      rem;
      logic [1:0][NUM_W-1:0]      nq;
   } div_stage_type;

endpackage

>>> rtl/quadratic_root_solver.sv
// Pipeline order: capture, products, discriminant, square-root chain, numerators, divider chain, output register.
// Throughput: one item per cycle; busy is never raised, since every stage moves each cycle.
// Most of the latency comes from the chain of 34 square-root cells and 35 + FRAC_BITS divider cells.
// Reset (synchronous, active high) clears every valid bit, so no stale result is strobed.
// The receiver cannot stall: each result stands on rsp_data for exactly one cycle.
module quadratic_root_solver (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qrs_pkg::req_type req_data,
   output logic             rsp_strobe,
   output qrs_pkg::rsp_type rsp_data
);

   localparam logic [qrs_pkg::NUM_W-1:0] POS_LIM = qrs_pkg::NUM_W'(64'h7FFF_FFFF);
   localparam logic [qrs_pkg::NUM_W-1:0] NEG_LIM = qrs_pkg::NUM_W'(64'h8000_0000);

   // Saturating conversion of a quotient magnitude and sign to a 32-bit root.
   // Bit 32 of the result is the clamp flag.
   function automatic logic [32:0] sat_root(input logic neg,
                                            input logic [qrs_pkg::NUM_W-1:0] mag);
      logic [qrs_pkg::NUM_W-1:0] neg_mag;
      neg_mag = ~mag + qrs_pkg::NUM_W'(1);
      if (neg) begin
         if (mag > NEG_LIM) begin
            sat_root = {1'b1, 32'h8000_0000};
         end else begin
            sat_root = {1'b0, neg_mag[31:0]};
         end
      end else begin
         if (mag > POS_LIM) begin
            sat_root = {1'b1, 32'h7FFF_FFFF};
         end else begin
            sat_root = {1'b0, mag[31:0]};
         end
      end
   endfunction

   // Every stage advances each cycle, so the block always takes a new item.
   assign busy = 1'b0;

   // Stage 1: capture the coefficients.
   logic             s1_valid_ff;
   qrs_pkg::req_type s1_req_ff;

   always_ff @(posedge clock) begin
      s1_req_ff <= req_data;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
   end

   // Stage 2: the two 32 x 32 magnitude products b*b and a*c.
   logic [31:0] a_mag;
   logic [31:0] b_mag;
   logic [31:0] c_mag;

   always_comb begin
      a_mag = s1_req_ff.coef_a[31] ? (~s1_req_ff.coef_a + 32'd1) : s1_req_ff.coef_a;
      b_mag = s1_req_ff.coef_b[31] ? (~s1_req_ff.coef_b + 32'd1) : s1_req_ff.coef_b;
      c_mag = s1_req_ff.coef_c[31] ? (~s1_req_ff.coef_c + 32'd1) : s1_req_ff.coef_c;
   end

   logic             s2_valid_ff;
   qrs_pkg::req_type s2_req_ff;
   logic [63:0]      s2_bb_ff;
   logic [63:0]      s2_ac_ff;
   logic             s2_add_ff;

   always_ff @(posedge clock) begin
      s2_req_ff <= s1_req_ff;
      s2_bb_ff  <= b_mag * b_mag;
      s2_ac_ff  <= a_mag * c_mag;
      // When c is zero or a and c differ in sign, -4ac adds to b*b.
      s2_add_ff <= (s1_req_ff.coef_c == 32'sd0)
                   | (s1_req_ff.coef_a[31] ^ s1_req_ff.coef_c[31]);
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage 3: the exact discriminant, the case code, and the operands of the divisions.
   // The radicand is forced to zero unless two roots are needed, so the square
   // root then comes out as zero and the numerators need no further selection.
   logic [65:0]           four_ac;
   logic [65:0]           disc_sum;
   logic [66:0]           disc_diff;
   logic [65:0]           disc;
   logic                  disc_neg;
   logic                  disc_zero;
   logic                  a_zero;
   logic                  b_zero;
   logic                  c_zero;
   logic signed [32:0]    b_ext;
   logic signed [32:0]    c_ext;
   logic signed [32:0]    den;
   qrs_pkg::sq_stage_type sq_head_in;
   qrs_pkg::sq_stage_type sq_head_ff;

   always_comb begin
      four_ac   = {s2_ac_ff, 2'b00};
      disc_sum  = {2'b00, s2_bb_ff} + four_ac;
      disc_diff = {3'b000, s2_bb_ff} - {1'b0, four_ac};
      if (s2_add_ff) begin
         disc     = disc_sum;
         disc_neg = 1'b0;
      end else begin
         disc     = disc_diff[65:0];
         disc_neg = disc_diff[66];
      end
      disc_zero = (disc == 66'd0);

      a_zero = (s2_req_ff.coef_a == 32'sd0);
      b_zero = (s2_req_ff.coef_b == 32'sd0);
      c_zero = (s2_req_ff.coef_c == 32'sd0);
      b_ext  = {s2_req_ff.coef_b[31], s2_req_ff.coef_b};
      c_ext  = {s2_req_ff.coef_c[31], s2_req_ff.coef_c};

      sq_head_in       = '0;
      sq_head_in.valid = s2_valid_ff & ~reset;
      if (a_zero) begin
         if (b_zero) begin
            sq_head_in.pay.code = c_zero ? qrs_pkg::CODE_INF : qrs_pkg::CODE_NONE;
         end else begin
            sq_head_in.pay.code = qrs_pkg::CODE_LIN;
         end
      end else if (disc_neg) begin
         sq_head_in.pay.code = qrs_pkg::CODE_NONE;
      end else if (disc_zero) begin
         sq_head_in.pay.code = qrs_pkg::CODE_DBL;
      end else begin
         sq_head_in.pay.code = qrs_pkg::CODE_TWO;
      end

      if (sq_head_in.pay.code == qrs_pkg::CODE_TWO) begin
         sq_head_in.rad = {2'b00, disc};
      end

      // Linear case: -c / b. Otherwise the divisor is 2a.
      den                    = a_zero ? b_ext : {s2_req_ff.coef_a, 1'b0};
      sq_head_in.pay.base1   = a_zero ? -c_ext : -b_ext;
      sq_head_in.pay.negb    = -b_ext;
      sq_head_in.pay.den_neg = den[32];
      sq_head_in.pay.den_mag = den[32] ? (~den + 33'sd1) : den;
   end

   always_ff @(posedge clock) begin
      sq_head_ff <= sq_head_in;
   end

   // Square-root chain: each cell settles one root bit.
   qrs_pkg::sq_stage_type sq_chain [0:qrs_pkg::SQRT_CELLS];

   assign sq_chain[0] = sq_head_ff;

   for (genvar i = 0; i < qrs_pkg::SQRT_CELLS; i++) begin : g_sqrt
      qrs_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .prev  (sq_chain[i]),
         .next  (sq_chain[i+1])
      );
   end

   // Numerator stage: -b + s and -b - s (or -c in the linear case), as magnitude and sign.
   qrs_pkg::sq_stage_type  sq_tail;
   logic signed [35:0]     num_one;
   logic signed [35:0]     num_two;
   logic [35:0]            mag_one;
   logic [35:0]            mag_two;
   qrs_pkg::div_stage_type div_head_in;
   qrs_pkg::div_stage_type div_head_ff;

   always_comb begin
      sq_tail = sq_chain[qrs_pkg::SQRT_CELLS];
      num_one = 36'(sq_tail.pay.base1) + $signed({2'b00, sq_tail.root});
      num_two = 36'(sq_tail.pay.negb) - $signed({2'b00, sq_tail.root});
      mag_one = num_one[35] ? (~num_one + 36'sd1) : num_one;
      mag_two = num_two[35] ? (~num_two + 36'sd1) : num_two;

      div_head_in            = '0;
      div_head_in.valid      = sq_tail.valid & ~reset;
      div_head_in.pay.code   = sq_tail.pay.code;
      div_head_in.pay.neg[0] = num_one[35] ^ sq_tail.pay.den_neg;
      div_head_in.pay.neg[1] = num_two[35] ^ sq_tail.pay.den_neg;
      div_head_in.den        = sq_tail.pay.den_mag;
      div_head_in.nq[0]      = {mag_one[34:0], {qrs_pkg::FRAC_BITS{1'b0}}};
      div_head_in.nq[1]      = {mag_two[34:0], {qrs_pkg::FRAC_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      div_head_ff <= div_head_in;
   end

   // Divider chain: each cell settles one quotient bit of both roots.
   qrs_pkg::div_stage_type div_chain [0:qrs_pkg::DIV_CELLS];

   assign div_chain[0] = div_head_ff;

   for (genvar i = 0; i < qrs_pkg::DIV_CELLS; i++) begin : g_div
      qrs_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .prev  (div_chain[i]),
         .next  (div_chain[i+1])
      );
   end

   // Output stage: apply signs, clamp to the 32-bit range, and pick fields by case.
   qrs_pkg::div_stage_type div_tail;
   logic [32:0]            res_one;
   logic [32:0]            res_two;
   qrs_pkg::rsp_type       rsp_in;
   qrs_pkg::rsp_type       rsp_ff;
   logic                   strobe_ff;

   always_comb begin
      div_tail         = div_chain[qrs_pkg::DIV_CELLS];
      res_one          = sat_root(div_tail.pay.neg[0], div_tail.nq[0]);
      res_two          = sat_root(div_tail.pay.neg[1], div_tail.nq[1]);
      rsp_in           = '0;
      rsp_in.case_code = div_tail.pay.code;
      unique case (div_tail.pay.code) inside
         qrs_pkg::CODE_INF, qrs_pkg::CODE_NONE: begin
         end
         qrs_pkg::CODE_LIN, qrs_pkg::CODE_DBL: begin
            rsp_in.root_one  = res_one[31:0];
            rsp_in.saturated = res_one[32];
         end
         qrs_pkg::CODE_TWO: begin
            rsp_in.root_one  = res_one[31:0];
            rsp_in.root_two  = res_two[31:0];
            rsp_in.saturated = res_one[32] | res_two[32];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= div_tail.valid;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // Every accepted item is answered after the fixed pipeline latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start & ~busy) |-> ##(qrs_pkg::LATENCY) rsp_strobe)
      else $error("result strobe missing after pipeline latency");

   // Cases without a root report zero roots and no clamp.
   a_no_root: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.case_code == qrs_pkg::CODE_INF
                     || rsp_data.case_code == qrs_pkg::CODE_NONE)
      |-> (rsp_data.root_one == 32'sd0) && (rsp_data.root_two == 32'sd0)
          && !rsp_data.saturated)
      else $error("root reported in a case without roots");

   // Only the two-root case fills the second root.
   a_root_two: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.case_code != qrs_pkg::CODE_TWO)
      |-> (rsp_data.root_two == 32'sd0))
      else $error("second root set outside the two-root case");

   // A clamp leaves at least one root at a range limit.
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.saturated
      |-> (rsp_data.root_one == 32'sh7FFF_FFFF) || (rsp_data.root_one == 32'sh8000_0000)
          || (rsp_data.root_two == 32'sh7FFF_FFFF)
          || (rsp_data.root_two == 32'sh8000_0000))
      else $error("saturation flag without a clamped root");

endmodule

>>> rtl/qrs_sqrt_cell.sv
// One bit of a restoring square root: two radicand bits in, one root bit out.
module qrs_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  qrs_pkg::sq_stage_type prev,
   output qrs_pkg::sq_stage_type next
);

   qrs_pkg::sq_stage_type stage_ff;
   qrs_pkg::sq_stage_type stage_in;
   logic [qrs_pkg::REM_W-1:0] rem_t;
   logic [qrs_pkg::REM_W-1:0] trial;

   always_comb begin
      rem_t          = {prev.rem[qrs_pkg::REM_W-3:0], prev.rad[qrs_pkg::RAD_W-1 -: 2]};
      trial          = {prev.root, 2'b01};
      stage_in       = prev;
      stage_in.valid = prev.valid & ~reset;
      stage_in.rad   = {prev.rad[qrs_pkg::RAD_W-3:0], 2'b00};
      if (rem_t >= trial) begin
         stage_in.rem  = rem_t - trial;
         stage_in.root = {prev.root[qrs_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         stage_in.rem  = rem_t;
         stage_in.root = {prev.root[qrs_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign next = stage_ff;

endmodule

>>> rtl/qrs_div_cell.sv
// One quotient bit of a restoring divider, for two numerators over a shared divisor.
module qrs_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  qrs_pkg::div_stage_type prev,
   output qrs_pkg::div_stage_type next
);

   qrs_pkg::div_stage_type stage_ff;
   qrs_pkg::div_stage_type stage_in;
   logic [qrs_pkg::DEN_W:0] part;

   always_comb begin
      part           = '0;
      stage_in       = prev;
      stage_in.valid = prev.valid & ~reset;
      for (int i = 0; i < 2; i++) begin
         part = {prev.rem[i], prev.nq[i][qrs_pkg::NUM_W-1]};
         if (part >= {1'b0, prev.den}) begin
            stage_in.rem[i] = qrs_pkg::DEN_W'(part - {1'b0, prev.den});
            stage_in.nq[i]  = {prev.nq[i][qrs_pkg::NUM_W-2:0], 1'b1};
         end else begin
            stage_in.rem[i] = part[qrs_pkg::DEN_W-1:0];
            stage_in.nq[i]  = {prev.nq[i][qrs_pkg::NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign next = stage_ff;

endmodule

>>> test/tb_quadratic_root_solver.sv
`timescale 1ns / 100ps

module tb_quadratic_root_solver;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   qrs_pkg::req_type req_data;
   logic             rsp_strobe;
   qrs_pkg::rsp_type rsp_data;

   quadratic_root_solver dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Coefficient sets waiting to be sent, and the root sets still owed by the block.
   qrs_pkg::req_type pending_coefs[$];
   qrs_pkg::rsp_type owed_roots[$];
   bit               failed;
   bit               stimulus_done;
   int               gap_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Quotient truncated toward zero, then clamped to the 32-bit signed range.
   function automatic logic signed [31:0] clamp_quotient(input logic signed [127:0] num,
                                                         input logic signed [127:0] den,
                                                         inout logic sat);
      logic signed [127:0] q;
      q = num / den;
      if (q > 128'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (q < -128'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return q[31:0];
   endfunction

   // Roots of a*x^2 + b*x + c = 0 in Q16.16, with the discriminant kept exact.
   function automatic qrs_pkg::rsp_type solve_roots(input qrs_pkg::req_type item);
      qrs_pkg::rsp_type    r;
      logic signed [127:0] a, b, c, disc, scale;
      logic [127:0]        root, trial;
      logic                sat;
      a = item.coef_a;
      b = item.coef_b;
      c = item.coef_c;
      scale = 128'sd1 <<< qrs_pkg::FRAC_BITS;
      sat = 1'b0;
      r = '0;
      if (a == 0) begin
         if (b == 0) begin
            r.case_code = (c == 0) ? qrs_pkg::CODE_INF : qrs_pkg::CODE_NONE;
         end else begin
            r.case_code = qrs_pkg::CODE_LIN;
            r.root_one = clamp_quotient(-c * scale, b, sat);
         end
      end else begin
         disc = b * b - 4 * a * c;
         if (disc < 0) begin
            r.case_code = qrs_pkg::CODE_NONE;
         end else if (disc == 0) begin
            r.case_code = qrs_pkg::CODE_DBL;
            r.root_one = clamp_quotient(-b * scale, 2 * a, sat);
         end else begin
            root = 0;
            for (int k = 33; k >= 0; k--) begin
               trial = root | (128'd1 << k);
               if (trial * trial <= disc) root = trial;
            end
            r.case_code = qrs_pkg::CODE_TWO;
            r.root_one = clamp_quotient((-b + $signed(root)) * scale, 2 * a, sat);
            r.root_two = clamp_quotient((-b - $signed(root)) * scale, 2 * a, sat);
         end
      end
      r.saturated = sat;
      return r;
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 9))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 32'h0;
         3: return $urandom_range(0, 1) ? 32'h10000 : 32'hffff0000;
         4, 5: return $urandom();
         6: return $signed($urandom_range(0, 255)) - 128;
         default: return ($signed($urandom_range(0, 63)) - 32) <<< qrs_pkg::FRAC_BITS;
      endcase
   endfunction

   // Builds equations with integer roots so that the double-root and two-root
   // cases come up often, alongside linear equations and random coefficients.
   task automatic add_random_item();
      qrs_pkg::req_type item;
      int               p, q, k;
      p = $signed($urandom_range(0, 40)) - 20;
      q = $signed($urandom_range(0, 40)) - 20;
      k = $signed($urandom_range(1, 8)) * ($urandom_range(0, 1) ? 1 : -1);
      case ($urandom_range(0, 5))
         0: begin
            item.coef_a = k <<< qrs_pkg::FRAC_BITS;
            item.coef_b = (-k * (p + q)) <<< qrs_pkg::FRAC_BITS;
            item.coef_c = (k * p * q) <<< qrs_pkg::FRAC_BITS;
         end
         1: begin
            item.coef_a = k <<< qrs_pkg::FRAC_BITS;
            item.coef_b = (-2 * k * p) <<< qrs_pkg::FRAC_BITS;
            item.coef_c = (k * p * p) <<< qrs_pkg::FRAC_BITS;
         end
         2: begin
            item.coef_a = 0;
            item.coef_b = rand_coef();
            item.coef_c = rand_coef();
         end
         default: begin
            item.coef_a = rand_coef();
            item.coef_b = rand_coef();
            item.coef_c = rand_coef();
         end
      endcase
      pending_coefs.push_back(item);
   endtask

   initial begin
      qrs_pkg::req_type item;
      logic [31:0]      edge_vals[6];
      edge_vals = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h10000, 32'hffff0000, 32'h1};
      // Directed part: linear and degenerate cases, extreme coefficients,
      // a double root, two roots, a negative discriminant and overflow.
      pending_coefs.push_back('{32'h0, 32'h0, 32'h0});
      pending_coefs.push_back('{32'h0, 32'h0, 32'h30000});
      pending_coefs.push_back('{32'h0, 32'h20000, 32'h40000});
      pending_coefs.push_back('{32'h0, 32'h1, 32'h7fffffff});
      pending_coefs.push_back('{32'h0, 32'hffffffff, 32'h80000000});
      pending_coefs.push_back('{32'h10000, 32'hfffe0000, 32'h10000});
      pending_coefs.push_back('{32'h10000, 32'h0, 32'hfffc0000});
      pending_coefs.push_back('{32'h10000, 32'h0, 32'h10000});
      pending_coefs.push_back('{32'h1, 32'h7fffffff, 32'h0});
      pending_coefs.push_back('{32'h80000000, 32'h80000000, 32'h7fffffff});
      pending_coefs.push_back('{32'h7fffffff, 32'h80000000, 32'h80000000});
      pending_coefs.push_back('{32'h80000000, 32'h7fffffff, 32'h80000000});
      pending_coefs.push_back('{32'hffffffff, 32'h0, 32'h7fffffff});
      for (int i = 0; i < 12; i++) begin
         item.coef_a = edge_vals[$urandom_range(0, 5)];
         item.coef_b = edge_vals[$urandom_range(0, 5)];
         item.coef_c = edge_vals[$urandom_range(0, 5)];
         pending_coefs.push_back(item);
      end
      for (int i = 0; i < 1750; i++) add_random_item();
      stimulus_done = 1'b1;
   end

   // Driver: start is raised only when the drawn gap has run out; an item
   // leaves the queue at the edge where start is high and busy is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         gap_left <= $urandom_range(0, 11);
      end else begin
         if (start && !busy) begin
            owed_roots.push_back(solve_roots(req_data));
            void'(pending_coefs.pop_front());
         end
         if (start && busy) begin
            // Hold the same item until the block takes it.
         end else if (gap_left > 0 || pending_coefs.size() == 0) begin
            start <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            start <= 1'b1;
            req_data <= pending_coefs[0];
            // Some stretches run back to back with no gap at all.
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         end
      end
   end

   // Monitor: every strobed result is compared with the oldest owed root set.
   always @(posedge clock) begin
      qrs_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (owed_roots.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            failed = 1'b1;
         end else begin
            want = owed_roots.pop_front();
            if (rsp_data.case_code !== want.case_code) begin
               $display("%0t: case_code expected %0d actual %0d", $time, want.case_code,
                        rsp_data.case_code);
               failed = 1'b1;
            end
            if (rsp_data.root_one !== want.root_one) begin
               $display("%0t: root_one expected %h actual %h", $time, want.root_one,
                        rsp_data.root_one);
               failed = 1'b1;
            end
            if (rsp_data.root_two !== want.root_two) begin
               $display("%0t: root_two expected %h actual %h", $time, want.root_two,
                        rsp_data.root_two);
               failed = 1'b1;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                        rsp_data.saturated);
               failed = 1'b1;
            end
         end
      end
   end

   // Reset once, then wait for every item to go out and every result to come back.
   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && pending_coefs.size() == 0 && owed_roots.size() == 0);
      repeat (qrs_pkg::LATENCY + 10) @(posedge clock);
      if (!failed && owed_roots.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond 1800 items times the longest gap plus the pipeline depth.
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> filelist.f
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver.sv
test/tb_quadratic_root_solver.sv
